### rtl/rtp_pkg.sv
// Shared types and constants of the RGB triplet text parser.
package rtp_pkg;

	localparam int BUFFER_BYTES = 64;
	localparam int QUEUE_DEPTH  = 4;

	localparam logic [7:0] CH_NUL    = 8'd0;
	localparam logic [7:0] CH_TAB    = 8'd9;
	localparam logic [7:0] CH_CR     = 8'd13;
	localparam logic [7:0] CH_SPACE  = 8'd32;
	localparam logic [7:0] CH_PLUS   = 8'd43;
	localparam logic [7:0] CH_COMMA  = 8'd44;
	localparam logic [7:0] CH_MINUS  = 8'd45;
	localparam logic [7:0] CH_PERIOD = 8'd46;
	localparam logic [7:0] CH_DIG0   = 8'd48;
	localparam logic [7:0] CH_DIG9   = 8'd57;

	// Character classes as seen by the parser
	typedef enum logic [2:0] {
		CL_PERIOD,
		CL_NUL,
		CL_SPACE,
		CL_SIGN,
		CL_DIGIT,
		CL_COMMA,
		CL_OTHER
	} cls_t;

	typedef struct packed {
		cls_t       cls;
		logic       minus;
		logic [3:0] digit;
	} tok_t;

endpackage

### rtl/rgb_triplet_text_parser_top.sv
// Top level of the RGB triplet text parser.
//
//   channel   signals                               request
//   byte      byte_valid/byte_ready, byte_in        one received character
//   rgb       rgb_valid/rgb_ready, red, green,      one parsed message,
//             blue, fields_matched                  sent on each period
//
// One byte is taken per cycle unless the queue is full; a period goes through the
// token queue and the result register. The back end retires one token per cycle
// unless a period stalls it. A token queue of QUEUE_DEPTH entries decouples byte
// intake from the parser. While a result waits, a following period stalls the
// parser and the queue fills. Reset clears control state; no clear pass is needed.
module rgb_triplet_text_parser_top #(
	parameter int BUFFER_BYTES = rtp_pkg::BUFFER_BYTES,
	parameter int QUEUE_DEPTH  = rtp_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] byte_in,
	input  logic       byte_valid,
	output logic       byte_ready,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue,
	output logic [1:0] fields_matched,
	output logic       rgb_valid,
	input  logic       rgb_ready
);

	rtp_pkg::tok_t wr_tok;
	rtp_pkg::tok_t rd_tok;
	logic          push;
	logic          q_full;
	logic          q_valid;
	logic          q_pop;

	rtp_front #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_in   (byte_in),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.q_full    (q_full),
		.push      (push),
		.tok       (wr_tok)
	);

	rtp_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_tok  (wr_tok),
		.full    (q_full),
		.rd_valid(q_valid),
		.pop     (q_pop),
		.rd_tok  (rd_tok)
	);

	rtp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.tok_valid     (q_valid),
		.tok           (rd_tok),
		.tok_pop       (q_pop),
		.red           (red),
		.green         (green),
		.blue          (blue),
		.fields_matched(fields_matched),
		.rgb_valid     (rgb_valid),
		.rgb_ready     (rgb_ready)
	);

endmodule

### rtl/rtp_front.sv
// Front end: accepts bytes, limits message length and classifies characters.
module rtp_front #(
	parameter int BUFFER_BYTES = rtp_pkg::BUFFER_BYTES
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [7:0]    byte_in,
	input  logic          byte_valid,
	output logic          byte_ready,
	input  logic          q_full,
	output logic          push,
	output rtp_pkg::tok_t tok
);

	localparam int CW = $clog2(BUFFER_BYTES);
	localparam logic [CW-1:0] KEEP_MAX = CW'(BUFFER_BYTES - 1);

	logic [CW-1:0] kept_q;
	logic          take;
	logic          is_period;

	assign byte_ready = !q_full;
	assign take       = byte_valid && byte_ready;
	assign is_period  = (byte_in == rtp_pkg::CH_PERIOD);
	// drop bytes beyond the buffer, but always pass the period
	assign push       = take && (is_period || (kept_q < KEEP_MAX));

	always_comb begin
		tok.minus = (byte_in == rtp_pkg::CH_MINUS);
		tok.digit = byte_in[3:0];
		if (is_period) begin
			tok.cls = rtp_pkg::CL_PERIOD;
		end else if (byte_in == rtp_pkg::CH_NUL) begin
			tok.cls = rtp_pkg::CL_NUL;
		end else if (byte_in inside {[rtp_pkg::CH_TAB:rtp_pkg::CH_CR], rtp_pkg::CH_SPACE}) begin
			tok.cls = rtp_pkg::CL_SPACE;
		end else if (byte_in inside {rtp_pkg::CH_PLUS, rtp_pkg::CH_MINUS}) begin
			tok.cls = rtp_pkg::CL_SIGN;
		end else if (byte_in inside {[rtp_pkg::CH_DIG0:rtp_pkg::CH_DIG9]}) begin
			tok.cls = rtp_pkg::CL_DIGIT;
		end else if (byte_in == rtp_pkg::CH_COMMA) begin
			tok.cls = rtp_pkg::CL_COMMA;
		end else begin
			tok.cls = rtp_pkg::CL_OTHER;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kept_q <= '0;
		end else if (take) begin
			if (is_period) begin
				kept_q <= '0;
			end else if (kept_q < KEEP_MAX) begin
				kept_q <= kept_q + 1'b1;
			end
		end
	end

endmodule

### rtl/rtp_queue.sv
// Short token queue between the front end and the parser.
module rtp_queue #(
	parameter int DEPTH = rtp_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  rtp_pkg::tok_t wr_tok,
	output logic          full,
	output logic          rd_valid,
	input  logic          pop,
	output rtp_pkg::tok_t rd_tok
);

	localparam int AW = $clog2(DEPTH);
	localparam int NW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
	localparam logic [NW-1:0] FULL_N = NW'(DEPTH);

	rtp_pkg::tok_t  mem_q [DEPTH];
	logic [AW-1:0]  wr_q;
	logic [AW-1:0]  rd_q;
	logic [NW-1:0]  cnt_q;
	logic           do_pop;

	assign full     = (cnt_q == FULL_N);
	assign rd_valid = (cnt_q != '0);
	assign rd_tok   = mem_q[rd_q];
	assign do_pop   = pop && rd_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wr_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == LAST) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == LAST) ? '0 : rd_q + 1'b1;
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### rtl/rtp_back.sv
// Parser back end: field state machine and result register.
module rtp_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          tok_valid,
	input  rtp_pkg::tok_t tok,
	output logic          tok_pop,
	output logic [7:0]    red,
	output logic [7:0]    green,
	output logic [7:0]    blue,
	output logic [1:0]    fields_matched,
	output logic          rgb_valid,
	input  logic          rgb_ready
);

	typedef enum logic [2:0] {
		PH_START  = 3'b001,
		PH_SIGN   = 3'b010,
		PH_DIGITS = 3'b100
	} phase_t;

	phase_t     phase_q, phase_d;
	logic [7:0] acc_q, acc_d;
	logic       neg_q, neg_d;
	logic       stop_q, stop_d;
	logic [1:0] idx_q, idx_c, idx_d;
	logic [7:0] vals_q [3];
	logic [7:0] vals_c [3];
	logic [7:0] vals_d [3];
	logic [7:0] commit_val;
	logic       commit;
	logic       is_period;
	logic       take;
	logic       out_valid_q;

	assign is_period  = (tok.cls == rtp_pkg::CL_PERIOD);
	// a period waits until the result register is free
	assign tok_pop    = !is_period || !out_valid_q || rgb_ready;
	assign take       = tok_valid && tok_pop;
	assign commit_val = neg_q ? (8'd0 - acc_q) : acc_q;
	assign rgb_valid  = out_valid_q;

	always_comb begin
		phase_d = phase_q;
		acc_d   = acc_q;
		neg_d   = neg_q;
		stop_d  = stop_q;
		commit  = 1'b0;
		if (take) begin
			case (tok.cls)
				rtp_pkg::CL_PERIOD: begin
					commit = !stop_q && (phase_q == PH_DIGITS);
				end
				rtp_pkg::CL_NUL: begin
					commit = !stop_q && (phase_q == PH_DIGITS);
					stop_d = 1'b1;
				end
				default: begin
					if (!stop_q) begin
						case (phase_q)
							PH_START: begin
								if (tok.cls == rtp_pkg::CL_SIGN) begin
									neg_d   = tok.minus;
									phase_d = PH_SIGN;
								end else if (tok.cls == rtp_pkg::CL_DIGIT) begin
									acc_d   = {4'd0, tok.digit};
									phase_d = PH_DIGITS;
								end else if (tok.cls != rtp_pkg::CL_SPACE) begin
									stop_d = 1'b1;
								end
							end
							PH_SIGN: begin
								if (tok.cls == rtp_pkg::CL_DIGIT) begin
									acc_d   = {4'd0, tok.digit};
									phase_d = PH_DIGITS;
								end else begin
									stop_d = 1'b1;
								end
							end
							PH_DIGITS: begin
								if (tok.cls == rtp_pkg::CL_DIGIT) begin
									acc_d = (acc_q << 3) + (acc_q << 1) + {4'd0, tok.digit};
								end else begin
									commit = 1'b1;
									if (idx_q == 2'd2 || tok.cls != rtp_pkg::CL_COMMA) begin
										stop_d = 1'b1;
									end
								end
							end
							default: begin
								stop_d = 1'b1;
							end
						endcase
					end
				end
			endcase
		end

		vals_c = vals_q;
		idx_c  = idx_q;
		if (commit) begin
			if (idx_q != 2'd3) begin
				vals_c[idx_q] = commit_val;
			end
			idx_c   = idx_q + 1'b1;
			acc_d   = '0;
			neg_d   = 1'b0;
			phase_d = PH_START;
		end

		vals_d = vals_c;
		idx_d  = idx_c;
		// the period closes the message: start afresh
		if (take && is_period) begin
			vals_d  = '{default: 8'd0};
			idx_d   = '0;
			acc_d   = '0;
			neg_d   = 1'b0;
			stop_d  = 1'b0;
			phase_d = PH_START;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_START;
			acc_q       <= '0;
			neg_q       <= 1'b0;
			stop_q      <= 1'b0;
			idx_q       <= '0;
			vals_q      <= '{default: 8'd0};
			out_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
			neg_q   <= neg_d;
			stop_q  <= stop_d;
			idx_q   <= idx_d;
			vals_q  <= vals_d;
			if (take && is_period) begin
				out_valid_q <= 1'b1;
			end else if (rgb_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && is_period) begin
			red            <= vals_c[0];
			green          <= vals_c[1];
			blue           <= vals_c[2];
			fields_matched <= idx_c;
		end
	end

endmodule

### rtl/rtp_checker.sv
// Port-level checks of the RGB triplet text parser, bound to its top level.
module rtp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic [7:0] byte_in,
	input logic       byte_valid,
	input logic       byte_ready,
	input logic [7:0] red,
	input logic [7:0] green,
	input logic [7:0] blue,
	input logic [1:0] fields_matched,
	input logic       rgb_valid,
	input logic       rgb_ready
);

	a_reset_idle: assert property (@(posedge clk) !arst_n |-> !rgb_valid)
		else $error("result shown during reset");

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rgb_valid && !rgb_ready |=> rgb_valid)
		else $error("result withdrawn before it was taken");

	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rgb_valid && !rgb_ready |=> $stable(red) && $stable(green) && $stable(blue)
			&& $stable(fields_matched))
		else $error("result payload changed while stalled");

	a_blue_absent: assert property (@(posedge clk) disable iff (!arst_n)
		rgb_valid && fields_matched != 2'd3 |-> blue == 8'd0)
		else $error("blue set without a third field");

	a_green_red_absent: assert property (@(posedge clk) disable iff (!arst_n)
		rgb_valid && (fields_matched == 2'd0 || fields_matched == 2'd1)
			|-> green == 8'd0 && (fields_matched == 2'd1 || red == 8'd0))
		else $error("field value set beyond the matched count");

endmodule

bind rgb_triplet_text_parser_top rtp_checker u_rtp_checker (.*);
